@@ hdl/ogbu_pkg.sv @@
package ogbu_pkg;

  // Field widths
  localparam int OP_W      = 2;
  localparam int COORD_W   = 11;
  localparam int SCORE_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Default grid size
  localparam int GRID_COLS_DEF = 128;
  localparam int GRID_ROWS_DEF = 128;

  // Score limits and reset values
  localparam logic [SCORE_W-1:0] SCORE_MAX       = 8'd255;
  localparam logic [SCORE_W-1:0] RESET_SCORE     = 8'd127;
  localparam logic [SCORE_W-1:0] OCC_INC_RESET   = 8'd20;
  localparam logic [SCORE_W-1:0] FREE_DEC_RESET  = 8'd5;
  localparam logic [SCORE_W-1:0] UNKNOWN_RESET   = 8'd127;

  // Operation codes
  localparam logic [OP_W-1:0] OP_BEAM  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_INC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_DEC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN  = 2'd2;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_BEAM,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

@@ hdl/ogbu_ram.sv @@
module ogbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/occupancy_grid_beam_update.sv @@
// One request at a time: a new request is taken only in the idle state.
// A beam walks its traced cells, reading each and writing it back; a clear sweeps every cell.
// Reset is asynchronous, active low. After reset a sweep writes the reset score into every
// cell with in_ready_o low; config writes are taken throughout.
module occupancy_grid_beam_update #(
  parameter int GRID_COLS = ogbu_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = ogbu_pkg::GRID_ROWS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ogbu_pkg::OP_W-1:0]            op_i,
  input  logic signed [ogbu_pkg::COORD_W-1:0]  from_x_i,
  input  logic signed [ogbu_pkg::COORD_W-1:0]  from_y_i,
  input  logic signed [ogbu_pkg::COORD_W-1:0]  to_x_i,
  input  logic signed [ogbu_pkg::COORD_W-1:0]  to_y_i,
  input  logic [ogbu_pkg::SCORE_W-1:0]         fill_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ogbu_pkg::SCORE_W-1:0]         score_o,
  output logic                                 status_o,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ogbu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ogbu_pkg::SCORE_W-1:0]         cfg_data_i
);
  import ogbu_pkg::*;

  // Grid geometry
  localparam int X_W   = $clog2(GRID_COLS);
  localparam int Y_W   = $clog2(GRID_ROWS);
  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int A_W   = $clog2(DEPTH);
  // Bresenham error term: spans -dy .. dx, doubled for the step test
  localparam int E_W   = ((X_W > Y_W) ? X_W : Y_W) + 2;
  localparam int E2_W  = E_W + 1;

  // Cell address, row-major
  function automatic logic [A_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                               input logic [Y_W-1:0] y);
    return A_W'(y) * A_W'(GRID_COLS) + A_W'(x);
  endfunction

  function automatic logic col_ok(input logic signed [COORD_W-1:0] v);
    return !v[COORD_W-1] && ($unsigned(v) < COORD_W'(GRID_COLS));
  endfunction

  function automatic logic row_ok(input logic signed [COORD_W-1:0] v);
    return !v[COORD_W-1] && ($unsigned(v) < COORD_W'(GRID_ROWS));
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  // config registers
  logic [SCORE_W-1:0] occ_inc_q, free_dec_q, unknown_q;

  // sweep (reset fill and clear op)
  logic             init_q, init_d;
  logic [A_W-1:0]   sweep_q, sweep_d;
  logic [SCORE_W-1:0] fill_q, fill_d;

  // beam walker: current cell, end cell, deltas, step directions, error
  logic [X_W-1:0]        x_q, x_d, x1_q, x1_d, dx_q, dx_d;
  logic [Y_W-1:0]        y_q, y_d, y1_q, y1_d, dy_q, dy_d;
  logic                  sx_neg_q, sx_neg_d, sy_neg_q, sy_neg_d;
  logic signed [E_W-1:0] err_q, err_d;
  logic                  walk_q, walk_d;   // a cell read is still to be issued

  // read issued last cycle, written back this cycle
  logic            pend_q, pend_d;
  logic [A_W-1:0]  pend_addr_q, pend_addr_d;
  logic            pend_hit_q, pend_hit_d;

  // finished result waiting for the output register
  logic [SCORE_W-1:0] res_score_q, res_score_d;
  logic               res_status_q, res_status_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               status_q, status_d;

  // score RAM
  logic               ram_we;
  logic [A_W-1:0]     ram_waddr, ram_raddr;
  logic [SCORE_W-1:0] ram_wdata, ram_rdata;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic accept, from_ok, to_ok, sweep_last, out_load, hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign from_ok    = col_ok(from_x_i) && row_ok(from_y_i);
  assign to_ok      = col_ok(to_x_i) && row_ok(to_y_i);
  assign sweep_last = (sweep_q == A_W'(DEPTH - 1));
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign hit        = (x_q == x1_q) && (y_q == y1_q);

  // Endpoint coordinates inside the grid (only meaningful once range checks pass)
  logic [X_W-1:0] fx_c, tx_c;
  logic [Y_W-1:0] fy_c, ty_c;
  assign fx_c = from_x_i[X_W-1:0];
  assign tx_c = to_x_i[X_W-1:0];
  assign fy_c = from_y_i[Y_W-1:0];
  assign ty_c = to_y_i[Y_W-1:0];

  // ---------------------------------------------------------------------------
  // Bresenham step
  // ---------------------------------------------------------------------------
  logic signed [E2_W-1:0] e2, dx_s, dy_s, err_step;
  logic                   step_x, step_y;

  assign e2     = {err_q, 1'b0};
  assign dx_s   = $signed(E2_W'(dx_q));
  assign dy_s   = $signed(E2_W'(dy_q));
  assign step_x = (e2 >= -dy_s);
  assign step_y = (e2 <= dx_s);
  assign err_step = E2_W'(err_q) - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);

  // ---------------------------------------------------------------------------
  // Cell update: lower a traversed cell, raise the hit cell
  // ---------------------------------------------------------------------------
  logic [SCORE_W-1:0] lowered, raised;
  logic [SCORE_W:0]   raise_sum;

  assign lowered   = (ram_rdata <= free_dec_q) ? '0 : ram_rdata - free_dec_q;
  assign raise_sum = {1'b0, ram_rdata} + {1'b0, occ_inc_q};
  assign raised    = raise_sum[SCORE_W] ? SCORE_MAX : raise_sum[SCORE_W-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_BEAM:  state_d = (from_ok && to_ok) ? ST_BEAM : ST_DONE;
            OP_READ:  state_d = from_ok ? ST_READ : ST_DONE;
            OP_CLEAR: state_d = ST_SWEEP;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_BEAM: begin
        // walker finished and the hit cell is written back this cycle
        if (!walk_q) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    init_d       = init_q;
    sweep_d      = sweep_q;
    fill_d       = fill_q;
    x_d          = x_q;
    y_d          = y_q;
    x1_d         = x1_q;
    y1_d         = y1_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    sx_neg_d     = sx_neg_q;
    sy_neg_d     = sy_neg_q;
    err_d        = err_q;
    walk_d       = walk_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    pend_hit_d   = pend_hit_q;
    res_score_d  = res_score_q;
    res_status_d = res_status_q;

    ram_we    = 1'b0;
    ram_waddr = pend_addr_q;
    ram_wdata = pend_hit_q ? raised : lowered;
    ram_raddr = cell_addr(x_q, y_q);

    case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = fill_q;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_last) begin
          init_d = 1'b0;
        end
      end
      ST_IDLE: begin
        // a read request fetches its cell right away
        ram_raddr = cell_addr(fx_c, fy_c);
        if (accept) begin
          res_score_d  = '0;
          res_status_d = 1'b0;
          x_d          = fx_c;
          y_d          = fy_c;
          x1_d         = tx_c;
          y1_d         = ty_c;
          dx_d         = (tx_c > fx_c) ? tx_c - fx_c : fx_c - tx_c;
          dy_d         = (ty_c > fy_c) ? ty_c - fy_c : fy_c - ty_c;
          sx_neg_d     = !(fx_c < tx_c);
          sy_neg_d     = !(fy_c < ty_c);
          err_d        = $signed(E_W'(dx_d)) - $signed(E_W'(dy_d));
          walk_d       = 1'b1;
          pend_d       = 1'b0;
          case (op_i)
            OP_BEAM: begin
              if (!(from_ok && to_ok)) begin
                res_status_d = 1'b1;
              end
            end
            OP_READ: begin
              if (!from_ok) begin
                res_score_d  = unknown_q;
                res_status_d = 1'b1;
              end
            end
            OP_CLEAR: begin
              fill_d  = fill_value_i;
              sweep_d = '0;
            end
            default: res_status_d = 1'b1;
          endcase
        end
      end
      ST_BEAM: begin
        // write back the cell read last cycle, read the next one
        ram_we = pend_q;
        pend_d = walk_q;
        if (walk_q) begin
          pend_addr_d = cell_addr(x_q, y_q);
          pend_hit_d  = hit;
          if (hit) begin
            walk_d = 1'b0;
          end else begin
            err_d = err_step[E_W-1:0];
            if (step_x) begin
              x_d = sx_neg_q ? x_q - 1'b1 : x_q + 1'b1;
            end
            if (step_y) begin
              y_d = sy_neg_q ? y_q - 1'b1 : y_q + 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        res_score_d = ram_rdata;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register: holds a result until taken, loads the next one when free
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    score_d     = score_q;
    status_d    = status_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      score_d     = res_score_q;
      status_d    = res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign status_o    = status_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      init_q      <= 1'b1;
      sweep_q     <= '0;
      fill_q      <= RESET_SCORE;
      walk_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      sweep_q     <= sweep_d;
      fill_q      <= fill_d;
      walk_q      <= walk_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_inc_q  <= OCC_INC_RESET;
      free_dec_q <= FREE_DEC_RESET;
      unknown_q  <= UNKNOWN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OCC_INC:  occ_inc_q  <= cfg_data_i;
        CFG_FREE_DEC: free_dec_q <= cfg_data_i;
        CFG_UNKNOWN:  unknown_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    y_q          <= y_d;
    x1_q         <= x1_d;
    y1_q         <= y1_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    sx_neg_q     <= sx_neg_d;
    sy_neg_q     <= sy_neg_d;
    err_q        <= err_d;
    pend_addr_q  <= pend_addr_d;
    pend_hit_q   <= pend_hit_d;
    res_score_q  <= res_score_d;
    res_status_q <= res_status_d;
    score_q      <= score_d;
    status_q     <= status_d;
  end

  // ---------------------------------------------------------------------------
  // Score memory
  // ---------------------------------------------------------------------------
  ogbu_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (DEPTH)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
